/* sv/pia_pkg.sv */
// Shared types and constants for the peripheral interface adapter.
package pia_pkg;

   // Request kinds carried on the request channel.
   typedef enum logic [2:0] {
      REQ_BUS_READ  = 3'd0,
      REQ_BUS_WRITE = 3'd1,
      REQ_CA1_LEVEL = 3'd2,
      REQ_CA2_LEVEL = 3'd3,
      REQ_CB1_LEVEL = 3'd4,
      REQ_CB2_LEVEL = 3'd5
   } req_kind_type;

   // Line-2 control modes in control bits 5..3.
   localparam logic [2:0] MODE_STROBE_LINE1 = 3'b100;
   localparam logic [2:0] MODE_STROBE_CLOCK = 3'b101;
   localparam logic [2:0] MODE_RESET        = 3'b110;
   localparam logic [2:0] MODE_SET          = 3'b111;

   // Writable part of a control register; bits 7 and 6 are the flags.
   localparam logic [7:0] FLAG_MASK = 8'h3F;

   // Control register bit positions.
   localparam int unsigned CR_IRQ1_EN   = 0;
   localparam int unsigned CR_EDGE1     = 1;
   localparam int unsigned CR_PORT_SEL  = 2;
   localparam int unsigned CR_IRQ2_EN   = 3;
   localparam int unsigned CR_EDGE2     = 4;
   localparam int unsigned CR_FLAG2     = 6;
   localparam int unsigned CR_FLAG1     = 7;

   // Line-2 mode field of a control register.
   function automatic logic [2:0] line2_mode(input logic [7:0] cr);
      return cr[5:3];
   endfunction

   // True when a level change is the edge selected by the control bit.
   function automatic logic active_edge(input logic oldv, input logic newv,
                                        input logic edge_sel);
      return (oldv != newv) && (edge_sel == newv);
   endfunction

endpackage

/* sv/peripheral_interface_adapter.sv */
// Peripheral interface adapter: register file, control lines and result register.
// A request accepted at a clock edge shows its result from that edge on.
// Throughput: one request per cycle; the single result register sets the rate, and a
// new request is taken whenever the result register is empty or is taken that cycle.
// Reset: synchronous, active high; clears all control, port and direction registers,
// the four control-line levels and the result valid flag.
module peripheral_interface_adapter
   import pia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic [1:0] req_reg_sel,
   input  logic [7:0] req_wdata,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_rdata,
   output logic       rsp_irq_a_event,
   output logic       rsp_irq_b_event,
   output logic       rsp_ca2_line,
   output logic       rsp_ca2_pulse,
   output logic       rsp_cb2_line,
   output logic       rsp_cb2_pulse,
   output logic [7:0] rsp_port_a_value,
   output logic [7:0] rsp_port_b_value
);

   // Adapter state.
   logic [7:0] ctrl_a_ff, ctrl_a_in, ctrl_b_ff, ctrl_b_in;
   logic [7:0] outreg_a_ff, outreg_a_in, outreg_b_ff, outreg_b_in;
   logic [7:0] dirreg_a_ff, dirreg_a_in, dirreg_b_ff, dirreg_b_in;
   logic       ca1_level_ff, ca1_level_in, ca2_level_ff, ca2_level_in;
   logic       cb1_level_ff, cb1_level_in, cb2_level_ff, cb2_level_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rdata_ff, rdata_in;
   logic       irq_a_ff, irq_a_in, irq_b_ff, irq_b_in;
   logic       pulse_a_ff, pulse_a_in, pulse_b_ff, pulse_b_in;

   logic       accept;
   logic       side_b, is_ctrl, lvl;
   logic [7:0] ctrl_new;

   // The request side waits only while a held result is not being taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign side_b  = req_reg_sel[1];
   assign is_ctrl = req_reg_sel[0];
   assign lvl     = req_wdata[0];

   // Decode one request against the current state.
   always_comb begin
      ctrl_a_in    = ctrl_a_ff;
      ctrl_b_in    = ctrl_b_ff;
      outreg_a_in  = outreg_a_ff;
      outreg_b_in  = outreg_b_ff;
      dirreg_a_in  = dirreg_a_ff;
      dirreg_b_in  = dirreg_b_ff;
      ca1_level_in = ca1_level_ff;
      ca2_level_in = ca2_level_ff;
      cb1_level_in = cb1_level_ff;
      cb2_level_in = cb2_level_ff;
      rdata_in     = 8'h00;
      irq_a_in     = 1'b0;
      irq_b_in     = 1'b0;
      pulse_a_in   = 1'b0;
      pulse_b_in   = 1'b0;
      ctrl_new     = 8'h00;

      case (req_type)
         REQ_BUS_READ: begin
            if (!side_b) begin
               if (is_ctrl) begin
                  rdata_in = ctrl_a_ff;
               end else if (ctrl_a_ff[CR_PORT_SEL]) begin
                  // Port read clears both flags and may strobe CA2.
                  rdata_in  = outreg_a_ff & dirreg_a_ff;
                  ctrl_a_in = ctrl_a_ff & FLAG_MASK;
                  if (line2_mode(ctrl_a_ff) == MODE_STROBE_LINE1) begin
                     ca2_level_in = 1'b0;
                  end else if (line2_mode(ctrl_a_ff) == MODE_STROBE_CLOCK) begin
                     ca2_level_in = 1'b1;
                     pulse_a_in   = 1'b1;
                  end
               end else begin
                  rdata_in = dirreg_a_ff;
               end
            end else begin
               if (is_ctrl) begin
                  rdata_in = ctrl_b_ff;
               end else if (ctrl_b_ff[CR_PORT_SEL]) begin
                  rdata_in  = outreg_b_ff & dirreg_b_ff;
                  ctrl_b_in = ctrl_b_ff & FLAG_MASK;
               end else begin
                  rdata_in = dirreg_b_ff;
               end
            end
         end
         REQ_BUS_WRITE: begin
            if (!side_b) begin
               if (is_ctrl) begin
                  // Flags are read-only; a newly enabled pending flag interrupts.
                  irq_a_in = (ctrl_a_ff[CR_FLAG1] && !ctrl_a_ff[CR_IRQ1_EN] &&
                              req_wdata[CR_IRQ1_EN]) ||
                             (ctrl_a_ff[CR_FLAG2] && !ctrl_a_ff[CR_IRQ2_EN] &&
                              req_wdata[CR_IRQ2_EN]);
                  ctrl_new  = (ctrl_a_ff & ~FLAG_MASK) | (req_wdata & FLAG_MASK);
                  ctrl_a_in = ctrl_new;
                  if (line2_mode(ctrl_new) == MODE_RESET) begin
                     ca2_level_in = 1'b0;
                  end else if (line2_mode(ctrl_new) == MODE_SET) begin
                     ca2_level_in = 1'b1;
                  end
               end else if (ctrl_a_ff[CR_PORT_SEL]) begin
                  outreg_a_in = req_wdata;
               end else begin
                  dirreg_a_in = req_wdata;
               end
            end else begin
               if (is_ctrl) begin
                  irq_b_in = (ctrl_b_ff[CR_FLAG1] && !ctrl_b_ff[CR_IRQ1_EN] &&
                              req_wdata[CR_IRQ1_EN]) ||
                             (ctrl_b_ff[CR_FLAG2] && !ctrl_b_ff[CR_IRQ2_EN] &&
                              req_wdata[CR_IRQ2_EN]);
                  ctrl_new  = (ctrl_b_ff & ~FLAG_MASK) | (req_wdata & FLAG_MASK);
                  ctrl_b_in = ctrl_new;
                  if (line2_mode(ctrl_new) == MODE_RESET) begin
                     cb2_level_in = 1'b0;
                  end else if (line2_mode(ctrl_new) == MODE_SET) begin
                     cb2_level_in = 1'b1;
                  end
               end else if (ctrl_b_ff[CR_PORT_SEL]) begin
                  // Port B write may strobe CB2.
                  outreg_b_in = req_wdata;
                  if (line2_mode(ctrl_b_ff) == MODE_STROBE_LINE1) begin
                     cb2_level_in = 1'b0;
                  end else if (line2_mode(ctrl_b_ff) == MODE_STROBE_CLOCK) begin
                     cb2_level_in = 1'b1;
                     pulse_b_in   = 1'b1;
                  end
               end else begin
                  dirreg_b_in = req_wdata;
               end
            end
         end
         REQ_CA1_LEVEL: begin
            ca1_level_in = lvl;
            if (active_edge(ca1_level_ff, lvl, ctrl_a_ff[CR_EDGE1])) begin
               ctrl_a_in[CR_FLAG1] = 1'b1;
               irq_a_in            = ctrl_a_ff[CR_IRQ1_EN];
               if (line2_mode(ctrl_a_ff) == MODE_STROBE_LINE1) begin
                  ca2_level_in = 1'b1;
               end
            end
         end
         REQ_CA2_LEVEL: begin
            ca2_level_in = lvl;
            if (active_edge(ca2_level_ff, lvl, ctrl_a_ff[CR_EDGE2])) begin
               ctrl_a_in[CR_FLAG2] = 1'b1;
               irq_a_in            = ctrl_a_ff[CR_IRQ2_EN];
            end
         end
         REQ_CB1_LEVEL: begin
            cb1_level_in = lvl;
            if (active_edge(cb1_level_ff, lvl, ctrl_b_ff[CR_EDGE1])) begin
               ctrl_b_in[CR_FLAG1] = 1'b1;
               irq_b_in            = ctrl_b_ff[CR_IRQ1_EN];
               if (line2_mode(ctrl_b_ff) == MODE_STROBE_LINE1) begin
                  cb2_level_in = 1'b1;
               end
            end
         end
         REQ_CB2_LEVEL: begin
            cb2_level_in = lvl;
            if (active_edge(cb2_level_ff, lvl, ctrl_b_ff[CR_EDGE2])) begin
               ctrl_b_in[CR_FLAG2] = 1'b1;
               irq_b_in            = ctrl_b_ff[CR_IRQ2_EN];
            end
         end
         default: begin
            // Unused request kinds leave the state alone.
            rdata_in = 8'h00;
         end
      endcase
   end

   // Result valid flag: set on a request, cleared when the result is taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff    <= 8'h00;
         ctrl_b_ff    <= 8'h00;
         outreg_a_ff  <= 8'h00;
         outreg_b_ff  <= 8'h00;
         dirreg_a_ff  <= 8'h00;
         dirreg_b_ff  <= 8'h00;
         ca1_level_ff <= 1'b0;
         ca2_level_ff <= 1'b0;
         cb1_level_ff <= 1'b0;
         cb2_level_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            ctrl_a_ff    <= ctrl_a_in;
            ctrl_b_ff    <= ctrl_b_in;
            outreg_a_ff  <= outreg_a_in;
            outreg_b_ff  <= outreg_b_in;
            dirreg_a_ff  <= dirreg_a_in;
            dirreg_b_ff  <= dirreg_b_in;
            ca1_level_ff <= ca1_level_in;
            ca2_level_ff <= ca2_level_in;
            cb1_level_ff <= cb1_level_in;
            cb2_level_ff <= cb2_level_in;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff   <= rdata_in;
         irq_a_ff   <= irq_a_in;
         irq_b_ff   <= irq_b_in;
         pulse_a_ff <= pulse_a_in;
         pulse_b_ff <= pulse_b_in;
      end
   end

   // Line levels and port values follow the state, which changes only with a new result.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rdata        = rdata_ff;
   assign rsp_irq_a_event  = irq_a_ff;
   assign rsp_irq_b_event  = irq_b_ff;
   assign rsp_ca2_line     = ca2_level_ff;
   assign rsp_ca2_pulse    = pulse_a_ff;
   assign rsp_cb2_line     = cb2_level_ff;
   assign rsp_cb2_pulse    = pulse_b_ff;
   assign rsp_port_a_value = outreg_a_ff & dirreg_a_ff;
   assign rsp_port_b_value = outreg_b_ff & dirreg_b_ff;

   // A bus-clock strobe always leaves its line high.
   a_pulse_a_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pulse_a_ff |-> ca2_level_ff)
      else $error("CA2 strobe reported with CA2 low");

   a_pulse_b_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pulse_b_ff |-> cb2_level_ff)
      else $error("CB2 strobe reported with CB2 low");

   // One request can strobe only one side.
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pulse_a_ff && pulse_b_ff))
      else $error("Both strobes reported for one request");

   // State holds while no request is accepted.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(ctrl_a_ff) && $stable(ctrl_b_ff) && $stable(ca2_level_ff))
      else $error("State changed without a request");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the peripheral interface adapter.
`timescale 1ns / 1ps

module tb;
   import pia_pkg::*;

   // Register select codes: bit 1 picks side B, bit 0 the control register.
   localparam logic [1:0] SEL_PORT_A = 2'b00;
   localparam logic [1:0] SEL_CTRL_A = 2'b01;
   localparam logic [1:0] SEL_PORT_B = 2'b10;
   localparam logic [1:0] SEL_CTRL_B = 2'b11;

   // Request codes the block does not define; it must ignore them.
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   // Line-2 input modes: bit 4 selects the rising edge, bit 3 enables the interrupt.
   localparam logic [2:0] MODE_IN_FALL     = 3'b000;
   localparam logic [2:0] MODE_IN_RISE_IRQ = 3'b011;

   localparam int unsigned QUIET_LIMIT   = 5000;
   localparam int unsigned RANDOM_ITEMS  = 1520;

   typedef struct packed {
      logic [7:0] rdata;
      logic       irq_a_event;
      logic       irq_b_event;
      logic       ca2_line;
      logic       ca2_pulse;
      logic       cb2_line;
      logic       cb2_pulse;
      logic [7:0] port_a_value;
      logic [7:0] port_b_value;
   } pia_result_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [2:0] req_type    = 3'd0;
   logic [1:0] req_reg_sel = 2'd0;
   logic [7:0] req_wdata   = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_rdata;
   logic       rsp_irq_a_event;
   logic       rsp_irq_b_event;
   logic       rsp_ca2_line;
   logic       rsp_ca2_pulse;
   logic       rsp_cb2_line;
   logic       rsp_cb2_pulse;
   logic [7:0] rsp_port_a_value;
   logic [7:0] rsp_port_b_value;

   // Shadow copy of the adapter's registers and control-line levels.
   logic [7:0] cr_a = '0, cr_b = '0, out_a = '0, out_b = '0, dir_a = '0, dir_b = '0;
   logic       lvl_ca1 = 1'b0, lvl_ca2 = 1'b0, lvl_cb1 = 1'b0, lvl_cb2 = 1'b0;

   pia_result_type expected_results[$];
   int unsigned failures     = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left   = 0;
   logic        steady       = 1'b0;

   peripheral_interface_adapter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_reg_sel      (req_reg_sel),
      .req_wdata        (req_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rdata        (rsp_rdata),
      .rsp_irq_a_event  (rsp_irq_a_event),
      .rsp_irq_b_event  (rsp_irq_b_event),
      .rsp_ca2_line     (rsp_ca2_line),
      .rsp_ca2_pulse    (rsp_ca2_pulse),
      .rsp_cb2_line     (rsp_cb2_line),
      .rsp_cb2_pulse    (rsp_cb2_pulse),
      .rsp_port_a_value (rsp_port_a_value),
      .rsp_port_b_value (rsp_port_b_value)
   );

   always #10 clock = ~clock;

   // Builds a control byte with both flags clear.
   function automatic logic [7:0] control_value(input logic [2:0] mode, input logic port_sel,
                                                input logic edge1, input logic irq1_en);
      return {2'b00, mode, port_sel, edge1, irq1_en};
   endfunction

   // Most gaps are short; a few are long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Control register write: the flags are kept, and setting an enable bit
   // while its flag is already up raises an interrupt.
   function automatic logic apply_control_write(inout logic [7:0] cr, input logic [7:0] v);
      logic raised;
      raised = (cr[CR_FLAG1] && !cr[CR_IRQ1_EN] && v[CR_IRQ1_EN]) ||
               (cr[CR_FLAG2] && !cr[CR_IRQ2_EN] && v[CR_IRQ2_EN]);
      cr = (cr & ~FLAG_MASK) | (v & FLAG_MASK);
      return raised;
   endfunction

   // Updates the shadow state for one request and returns the result it causes.
   function automatic pia_result_type predict_adapter(input logic [2:0] kind,
                                                      input logic [1:0] sel,
                                                      input logic [7:0] data);
      pia_result_type r;
      logic           side_b;
      logic           is_ctrl;
      logic           lvl;
      logic           hit;
      r       = '0;
      side_b  = sel[1];
      is_ctrl = sel[0];
      lvl     = data[0];
      case (kind)
         REQ_BUS_READ: begin
            if (!side_b && is_ctrl) begin
               r.rdata = cr_a;
            end else if (!side_b && cr_a[CR_PORT_SEL]) begin
               // A port read clears both flags and may strobe CA2.
               r.rdata = out_a & dir_a;
               cr_a    = cr_a & FLAG_MASK;
               if (cr_a[5:3] == MODE_STROBE_LINE1) begin
                  lvl_ca2 = 1'b0;
               end else if (cr_a[5:3] == MODE_STROBE_CLOCK) begin
                  lvl_ca2     = 1'b1;
                  r.ca2_pulse = 1'b1;
               end
            end else if (!side_b) begin
               r.rdata = dir_a;
            end else if (is_ctrl) begin
               r.rdata = cr_b;
            end else if (cr_b[CR_PORT_SEL]) begin
               r.rdata = out_b & dir_b;
               cr_b    = cr_b & FLAG_MASK;
            end else begin
               r.rdata = dir_b;
            end
         end
         REQ_BUS_WRITE: begin
            if (!side_b && is_ctrl) begin
               r.irq_a_event = apply_control_write(cr_a, data);
               if (cr_a[5:3] == MODE_RESET) lvl_ca2 = 1'b0;
               else if (cr_a[5:3] == MODE_SET) lvl_ca2 = 1'b1;
            end else if (!side_b && cr_a[CR_PORT_SEL]) begin
               out_a = data;
            end else if (!side_b) begin
               dir_a = data;
            end else if (is_ctrl) begin
               r.irq_b_event = apply_control_write(cr_b, data);
               if (cr_b[5:3] == MODE_RESET) lvl_cb2 = 1'b0;
               else if (cr_b[5:3] == MODE_SET) lvl_cb2 = 1'b1;
            end else if (cr_b[CR_PORT_SEL]) begin
               // A port B write may strobe CB2.
               out_b = data;
               if (cr_b[5:3] == MODE_STROBE_LINE1) begin
                  lvl_cb2 = 1'b0;
               end else if (cr_b[5:3] == MODE_STROBE_CLOCK) begin
                  lvl_cb2     = 1'b1;
                  r.cb2_pulse = 1'b1;
               end
            end else begin
               dir_b = data;
            end
         end
         REQ_CA1_LEVEL: begin
            hit     = (lvl_ca1 != lvl) && (cr_a[CR_EDGE1] == lvl);
            lvl_ca1 = lvl;
            if (hit) begin
               cr_a[CR_FLAG1] = 1'b1;
               r.irq_a_event  = cr_a[CR_IRQ1_EN];
               if (cr_a[5:3] == MODE_STROBE_LINE1) lvl_ca2 = 1'b1;
            end
         end
         REQ_CA2_LEVEL: begin
            hit     = (lvl_ca2 != lvl) && (cr_a[CR_EDGE2] == lvl);
            lvl_ca2 = lvl;
            if (hit) begin
               cr_a[CR_FLAG2] = 1'b1;
               r.irq_a_event  = cr_a[CR_IRQ2_EN];
            end
         end
         REQ_CB1_LEVEL: begin
            hit     = (lvl_cb1 != lvl) && (cr_b[CR_EDGE1] == lvl);
            lvl_cb1 = lvl;
            if (hit) begin
               cr_b[CR_FLAG1] = 1'b1;
               r.irq_b_event  = cr_b[CR_IRQ1_EN];
               if (cr_b[5:3] == MODE_STROBE_LINE1) lvl_cb2 = 1'b1;
            end
         end
         REQ_CB2_LEVEL: begin
            hit     = (lvl_cb2 != lvl) && (cr_b[CR_EDGE2] == lvl);
            lvl_cb2 = lvl;
            if (hit) begin
               cr_b[CR_FLAG2] = 1'b1;
               r.irq_b_event  = cr_b[CR_IRQ2_EN];
            end
         end
         default: begin
         end
      endcase
      r.ca2_line     = lvl_ca2;
      r.cb2_line     = lvl_cb2;
      r.port_a_value = out_a & dir_a;
      r.port_b_value = out_b & dir_b;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Checks each accepted result, then records the expectation of each accepted request.
   always @(posedge clock) begin
      pia_result_type want;
      logic           moved;
      moved = 1'b0;
      if (reset) begin
         {cr_a, cr_b, out_a, out_b, dir_a, dir_b} = '0;
         {lvl_ca1, lvl_ca2, lvl_cb1, lvl_cb2}     = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
               $error("result arrived with no request outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("rdata", want.rdata, rsp_rdata);
               check_field("irq_a_event", 8'(want.irq_a_event), 8'(rsp_irq_a_event));
               check_field("irq_b_event", 8'(want.irq_b_event), 8'(rsp_irq_b_event));
               check_field("ca2_line", 8'(want.ca2_line), 8'(rsp_ca2_line));
               check_field("ca2_pulse", 8'(want.ca2_pulse), 8'(rsp_ca2_pulse));
               check_field("cb2_line", 8'(want.cb2_line), 8'(rsp_cb2_line));
               check_field("cb2_pulse", 8'(want.cb2_pulse), 8'(rsp_cb2_pulse));
               check_field("port_a_value", want.port_a_value, rsp_port_a_value);
               check_field("port_b_value", want.port_b_value, rsp_port_b_value);
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            expected_results.push_back(predict_adapter(req_type, req_reg_sel, req_wdata));
         end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
   end

   // Result-side stalls come in segments of random length; none start in steady stretches.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left <= pick_gap();
      end
   end

   // Ends the run when nothing has moved on either channel for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb NOT OK");
      $finish;
   end

   // Presents one request and holds it until accepted; called at a rising edge.
   task automatic send_request(input logic [2:0] kind, input logic [1:0] sel,
                               input logic [7:0] data);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_reg_sel <= sel;
      req_wdata   <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Port A: direction access, flags read-only, bus-clock and CA1-restored strobes.
   task automatic test_port_a_strobes();
      send_request(REQ_BUS_READ, SEL_CTRL_A, 8'h00);
      send_request(REQ_BUS_WRITE, SEL_PORT_A, 8'hFF);
      send_request(REQ_BUS_READ, SEL_PORT_A, 8'h00);
      send_request(REQ_BUS_WRITE, SEL_CTRL_A,
                   8'hC0 | control_value(MODE_STROBE_CLOCK, 1'b1, 1'b0, 1'b0));
      send_request(REQ_BUS_WRITE, SEL_PORT_A, 8'hFF);
      send_request(REQ_BUS_READ, SEL_PORT_A, 8'h00);
      send_request(REQ_BUS_WRITE, SEL_CTRL_A,
                   control_value(MODE_STROBE_LINE1, 1'b1, 1'b1, 1'b1));
      send_request(REQ_BUS_READ, SEL_PORT_A, 8'h00);
      send_request(REQ_CA1_LEVEL, SEL_PORT_A, 8'h01);
      send_request(REQ_BUS_READ, SEL_CTRL_A, 8'h00);
      send_request(REQ_BUS_READ, SEL_PORT_A, 8'h00);
   endtask

   // Port B: write strobes and CB1 level changes, including a change of the wrong polarity.
   task automatic test_port_b_strobes();
      send_request(REQ_BUS_WRITE, SEL_PORT_B, 8'hFF);
      send_request(REQ_BUS_WRITE, SEL_CTRL_B,
                   control_value(MODE_STROBE_CLOCK, 1'b1, 1'b0, 1'b0));
      send_request(REQ_BUS_WRITE, SEL_PORT_B, 8'h00);
      send_request(REQ_BUS_WRITE, SEL_CTRL_B,
                   control_value(MODE_STROBE_LINE1, 1'b1, 1'b0, 1'b1));
      send_request(REQ_BUS_WRITE, SEL_PORT_B, 8'hFF);
      send_request(REQ_CB1_LEVEL, SEL_CTRL_A, 8'h01);
      send_request(REQ_CB1_LEVEL, SEL_PORT_A, 8'hFE);
   endtask

   // Enabling an interrupt while its flag is up reports it at once.
   task automatic test_pending_enable();
      send_request(REQ_BUS_WRITE, SEL_CTRL_B,
                   control_value(MODE_STROBE_LINE1, 1'b1, 1'b0, 1'b0));
      send_request(REQ_BUS_WRITE, SEL_CTRL_B,
                   control_value(MODE_STROBE_LINE1, 1'b1, 1'b0, 1'b1));
      send_request(REQ_BUS_READ, SEL_PORT_B, 8'h00);
   endtask

   // Line-2 as an interrupt input, then driven set and reset by the program.
   task automatic test_line2_modes();
      send_request(REQ_BUS_WRITE, SEL_CTRL_A,
                   control_value(MODE_IN_RISE_IRQ, 1'b0, 1'b0, 1'b0));
      send_request(REQ_CA2_LEVEL, SEL_CTRL_B, 8'hFF);
      send_request(REQ_BUS_WRITE, SEL_CTRL_B,
                   control_value(MODE_SET, 1'b0, 1'b0, 1'b0));
      send_request(REQ_CB2_LEVEL, SEL_PORT_B, 8'hFE);
      send_request(REQ_BUS_WRITE, SEL_CTRL_B,
                   control_value(MODE_RESET, 1'b0, 1'b0, 1'b0));
      send_request(REQ_BUS_WRITE, SEL_CTRL_A,
                   control_value(MODE_IN_FALL, 1'b1, 1'b0, 1'b0));
   endtask

   // Undefined request codes leave every register alone.
   task automatic test_unused_requests();
      send_request(REQ_SPARE_6, SEL_CTRL_B, 8'hFF);
      send_request(REQ_SPARE_7, SEL_PORT_A, 8'h5A);
   endtask

   // Mixed traffic with periodic control rewrites so that every mode gets exercised.
   task automatic test_random_traffic();
      logic [2:0]  kind;
      logic [1:0]  sel;
      logic [7:0]  data;
      int unsigned r;
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         steady = ((i / 200) % 3 == 1);
         if (i == RANDOM_ITEMS / 2) wait_for_results();
         sel  = 2'($urandom_range(0, 3));
         data = 8'($urandom_range(0, 255));
         r    = $urandom_range(0, 99);
         if (i % 48 == 0) begin
            // New control setting, usually with the port register selected.
            kind = REQ_BUS_WRITE;
            sel  = $urandom_range(0, 1) ? SEL_CTRL_B : SEL_CTRL_A;
            if ($urandom_range(0, 9) < 7) data[CR_PORT_SEL] = 1'b1;
         end else if (r < 22) begin
            kind = REQ_BUS_READ;
         end else if (r < 48) begin
            kind = REQ_BUS_WRITE;
            if ($urandom_range(0, 9) == 0) data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else if (r < 94) begin
            kind = 3'($urandom_range(REQ_CA1_LEVEL, REQ_CB2_LEVEL));
         end else begin
            kind = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
         end
         send_request(kind, sel, data);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_port_a_strobes();
      test_port_b_strobes();
      test_pending_enable();
      test_line2_modes();
      test_unused_requests();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
